/* rtl/core/ssps_pkg.sv */
// Package for the sphere surface point sampler.
// Holds the transaction structs, register codes, widths and the input conversion.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package ssps_pkg;

	// Width of each random fraction at the input.
	localparam int RAND_BITS = 16;
	// Fraction bits of the internal Q2.30 values.
	localparam int FRAC_BITS = 30;
	// Width of d, of the coordinates and of the registers.
	localparam int DW = 32;

	// Square root unit: radicand, root and partial remainder widths.
	localparam int SQ_RAD_W = 2 * DW;
	localparam int SQ_ROOT_W = SQ_RAD_W / 2;
	localparam int SQ_REM_W = SQ_ROOT_W + 4;
	// Result bits resolved in each square root stage.
	localparam int SQ_STEPS_PER_STAGE = 4;
	localparam int SQ_STAGES = SQ_ROOT_W / SQ_STEPS_PER_STAGE;

	// Cycles from an accepted start to the result strobe edge.
	localparam int LATENCY = 4 + SQ_STAGES + 5;

	// Configuration port.
	localparam int ADDR_W = 5;
	localparam int CFG_W = 32;

	// d = 1 at scale 2^-30.
	localparam logic [DW-1:0] ONE_D = DW'(1) << FRAC_BITS;

	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_SCALE_X  = 3'd3,
		REG_SCALE_Y  = 3'd4,
		REG_SCALE_Z  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [RAND_BITS-1:0] rand_a;
		logic [RAND_BITS-1:0] rand_b;
	} sample_t;

	typedef struct packed {
		logic signed [DW-1:0] point_x;
		logic signed [DW-1:0] point_y;
		logic signed [DW-1:0] point_z;
	} point_t;

	// Values that ride alongside the square root.
	typedef struct packed {
		logic signed [DW-1:0] d1;
		logic signed [DW-1:0] d2;
		logic signed [DW-1:0] cz;
	} side_t;

	// Working state of the digit-by-digit square root.
	typedef struct packed {
		logic [SQ_REM_W-1:0]  rem;
		logic [SQ_ROOT_W-1:0] root;
		logic [SQ_RAD_W-1:0]  rad;
	} sq_state_t;

	// Turns a random fraction into d = 1 - 2u at scale 2^-30 (exact).
	function automatic logic signed [DW-1:0] to_fixed(input logic [RAND_BITS-1:0] r);
		logic [RAND_BITS+FRAC_BITS-1:0] w;
		logic [FRAC_BITS-1:0]           q;
		w = {r, {FRAC_BITS{1'b0}}};
		q = w[RAND_BITS+FRAC_BITS-1 -: FRAC_BITS];
		return $signed(ONE_D - {1'b0, q, 1'b0});
	endfunction

endpackage

`default_nettype wire

/* rtl/core/ssps_sqrt.sv */
// Pipelined integer square root for the sphere surface point sampler.
// Resolves four root bits per stage and carries a side struct along.
// Depends on ssps_pkg.
`default_nettype none

module ssps_sqrt
	import ssps_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 vld_in,
	input  wire logic [SQ_RAD_W-1:0]  rad_in,
	input  wire side_t                side_in,
	output logic                      vld_out,
	output logic [SQ_ROOT_W-1:0]      root_out,
	output side_t                     side_out
);

	// One restoring step per result bit, several steps per stage.
	function automatic sq_state_t sq_stage(input sq_state_t st);
		sq_state_t            v;
		logic [SQ_REM_W-1:0]  cur;
		logic [SQ_REM_W-1:0]  trial;
		v = st;
		for (int i = 0; i < SQ_STEPS_PER_STAGE; i++) begin
			cur   = {v.rem[SQ_REM_W-3:0], v.rad[SQ_RAD_W-1 -: 2]};
			trial = SQ_REM_W'({v.root, 2'b01});
			if (cur >= trial) begin
				v.rem  = cur - trial;
				v.root = {v.root[SQ_ROOT_W-2:0], 1'b1};
			end else begin
				v.rem  = cur;
				v.root = {v.root[SQ_ROOT_W-2:0], 1'b0};
			end
			v.rad = {v.rad[SQ_RAD_W-3:0], 2'b00};
		end
		return v;
	endfunction

	sq_state_t sq_s   [SQ_STAGES];
	side_t     side_s [SQ_STAGES];
	logic      vld_s  [SQ_STAGES];
	sq_state_t stage_in  [SQ_STAGES];
	sq_state_t stage_out [SQ_STAGES];

	// The first stage starts from an empty remainder and root.
	assign stage_in[0] = '{rem: '0, root: '0, rad: rad_in};

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
		if (k > 0) begin : g_link
			assign stage_in[k] = sq_s[k-1];
		end

		assign stage_out[k] = sq_stage(stage_in[k]);

		// Valid bit of the stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= (k == 0) ? vld_in : vld_s[(k == 0) ? 0 : k-1];
			end
		end

		// Stage payload.
		always_ff @(posedge clk) begin
			sq_s[k]   <= stage_out[k];
			side_s[k] <= (k == 0) ? side_in : side_s[(k == 0) ? 0 : k-1];
		end
	end

	assign vld_out  = vld_s[SQ_STAGES-1];
	assign root_out = sq_s[SQ_STAGES-1].root;
	assign side_out = side_s[SQ_STAGES-1];

endmodule

`default_nettype wire

/* rtl/core/sphere_surface_point_sampler.sv */
// Sphere surface point sampler: top level with the register file and the datapath.
// Instantiates ssps_sqrt; depends on ssps_pkg.
//
// The block takes one pair of random fractions in every clock cycle and never
// raises busy. A pair whose s = d1^2 + d2^2 reaches one is dropped without a
// result; an accepted pair gives one point, strobed on point_valid for one cycle,
// once it has passed four stages in front of the eight-stage square root (four root
// bits per stage) and five after it for the coordinate and scale multiplications,
// rounding and saturation. The receiver cannot stall; there is no back pressure
// and no clearing pass. The user must see that registers are written through the
// APB port only while no transaction is in flight; the block does not enforce it.
`default_nettype none

module sphere_surface_point_sampler
	import ssps_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [CFG_W-1:0]  pwdata,
	output logic [CFG_W-1:0]       prdata,
	output logic                   pready,
	input  wire logic              start,
	output logic                   busy,
	input  wire sample_t           sample,
	output logic                   point_valid,
	output point_t                 point
);

	localparam logic [63:0] ONE60  = 64'(1) << (2 * FRAC_BITS);
	localparam logic [63:0] HALF28 = 64'(1) << (FRAC_BITS - 2);
	localparam logic [63:0] HALF29 = 64'(1) << (FRAC_BITS - 1);
	localparam logic signed [DW-1:0] SCALE_ONE = DW'(1) << 16;
	localparam logic signed [DW+2:0] SAT_MAX = (DW+3)'(2147483647);
	localparam logic signed [DW+2:0] SAT_MIN = ~SAT_MAX;

	// Rounds a Q2.30 by Q16.16 product (scale 2^-46) to Q18.16, ties toward plus infinity.
	function automatic logic signed [DW+1:0] round30(input logic signed [63:0] p);
		logic [63:0] t;
		t = p + HALF29;
		return $signed(t[63:FRAC_BITS]);
	endfunction

	// Adds the origin and clamps to the signed 32-bit range.
	function automatic logic signed [DW-1:0] sat_add(input logic signed [DW+1:0] v,
			input logic signed [DW-1:0] o);
		logic signed [DW+2:0] s;
		s = (DW+3)'(v) + (DW+3)'(o);
		if (s > SAT_MAX) begin
			return SAT_MAX[DW-1:0];
		end else if (s < SAT_MIN) begin
			return SAT_MIN[DW-1:0];
		end
		return s[DW-1:0];
	endfunction

	// Configuration registers.
	logic signed [DW-1:0] origin_x_q, origin_y_q, origin_z_q;
	logic signed [DW-1:0] scale_x_q, scale_y_q, scale_z_q;
	logic                 cfg_wr;
	cfg_reg_t             cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = cfg_reg_t'(paddr[ADDR_W-1:2]);

	// Register writes; an address beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			scale_x_q  <= SCALE_ONE;
			scale_y_q  <= SCALE_ONE;
			scale_z_q  <= SCALE_ONE;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ORIGIN_X: origin_x_q <= $signed(pwdata);
				REG_ORIGIN_Y: origin_y_q <= $signed(pwdata);
				REG_ORIGIN_Z: origin_z_q <= $signed(pwdata);
				REG_SCALE_X:  scale_x_q  <= $signed(pwdata);
				REG_SCALE_Y:  scale_y_q  <= $signed(pwdata);
				REG_SCALE_Z:  scale_z_q  <= $signed(pwdata);
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (cfg_idx)
			REG_ORIGIN_X: prdata = origin_x_q;
			REG_ORIGIN_Y: prdata = origin_y_q;
			REG_ORIGIN_Z: prdata = origin_z_q;
			REG_SCALE_X:  prdata = scale_x_q;
			REG_SCALE_Y:  prdata = scale_y_q;
			REG_SCALE_Z:  prdata = scale_z_q;
			default:      prdata = '0;
		endcase
	end

	// The pipeline never stalls, so every start is a transaction.
	assign busy = 1'b0;

	logic                   vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [DW-1:0]   d1_s1, d2_s1, d1_s2, d2_s2, d1_s3, d2_s3;
	logic [2*FRAC_BITS:0]   sqa_s2, sqb_s2;
	logic [2*FRAC_BITS+1:0] sum_c, sum_s3;
	logic signed [63:0]     sqa_c, sqb_c;
	logic [63:0]            rad_c, czt_c;
	logic [SQ_RAD_W-1:0]    rad_s4;
	side_t                  side_s4;

	assign sqa_c = d1_s1 * d1_s1;
	assign sqb_c = d2_s1 * d2_s1;
	assign sum_c = (2*FRAC_BITS+2)'(sqa_s2) + (2*FRAC_BITS+2)'(sqb_s2);
	assign rad_c = ONE60 - 64'(sum_s3);
	assign czt_c = ONE60 - {1'b0, sum_s3, 1'b0} + HALF29;

	// Front valid bits; a rejected pair drops its valid bit at stage three.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2 && (sum_c[2*FRAC_BITS+1:2*FRAC_BITS] == 2'b00);
			vld_s4 <= vld_s3;
		end
	end

	// Front payload: d values, squares, their sum, then 1 - s and z.
	always_ff @(posedge clk) begin
		d1_s1   <= to_fixed(sample.rand_a);
		d2_s1   <= to_fixed(sample.rand_b);
		d1_s2   <= d1_s1;
		d2_s2   <= d2_s1;
		sqa_s2  <= sqa_c[2*FRAC_BITS:0];
		sqb_s2  <= sqb_c[2*FRAC_BITS:0];
		d1_s3   <= d1_s2;
		d2_s3   <= d2_s2;
		sum_s3  <= sum_c;
		rad_s4  <= rad_c;
		side_s4 <= '{d1: d1_s3, d2: d2_s3, cz: $signed(czt_c[2*FRAC_BITS+1:FRAC_BITS])};
	end

	logic                 sq_vld;
	logic [SQ_ROOT_W-1:0] sq_root;
	side_t                sq_side;

	ssps_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld_s4),
		.rad_in   (rad_s4),
		.side_in  (side_s4),
		.vld_out  (sq_vld),
		.root_out (sq_root),
		.side_out (sq_side)
	);

	logic                   vld_s13, vld_s14, vld_s15, vld_s16, vld_s17;
	logic signed [63:0]     mx_s13, my_s13;
	logic signed [DW-1:0]   cz_s13, cx_s14, cy_s14, cz_s14;
	logic signed [63:0]     px_s15, py_s15, pz_s15;
	logic signed [DW+1:0]   rx_s16, ry_s16, rz_s16;
	logic signed [DW-1:0]   root_c;
	logic [63:0]            mxt_c, myt_c;
	point_t                 point_s17;

	assign root_c = $signed({1'b0, sq_root[DW-2:0]});
	assign mxt_c  = mx_s13 + HALF28;
	assign myt_c  = my_s13 + HALF28;

	// Back valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
		end else begin
			vld_s13 <= sq_vld;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
			vld_s17 <= vld_s16;
		end
	end

	// Back payload: d times root, rounding, axis scale, rounding, origin and clamp.
	always_ff @(posedge clk) begin
		mx_s13    <= sq_side.d1 * root_c;
		my_s13    <= sq_side.d2 * root_c;
		cz_s13    <= sq_side.cz;
		cx_s14    <= $signed(mxt_c[2*FRAC_BITS:FRAC_BITS-1]);
		cy_s14    <= $signed(myt_c[2*FRAC_BITS:FRAC_BITS-1]);
		cz_s14    <= cz_s13;
		px_s15    <= cx_s14 * scale_x_q;
		py_s15    <= cy_s14 * scale_y_q;
		pz_s15    <= cz_s14 * scale_z_q;
		rx_s16    <= round30(px_s15);
		ry_s16    <= round30(py_s15);
		rz_s16    <= round30(pz_s15);
		point_s17 <= '{point_x: sat_add(rx_s16, origin_x_q),
			point_y: sat_add(ry_s16, origin_y_q),
			point_z: sat_add(rz_s16, origin_z_q)};
	end

	assign point_valid = vld_s17;
	assign point       = point_s17;

`ifndef SYNTHESIS
	// A result always stems from a transaction accepted a fixed time earlier.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> $past(start && !busy, LATENCY))
		else $error("result without a matching transaction");

	// The square root of 1 - s never exceeds one.
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld |-> (sq_root <= SQ_ROOT_W'(ONE_D)))
		else $error("square root out of range");

	// The z coordinate lies within plus and minus one.
	a_cz_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s14 |-> (cz_s14 <= $signed(ONE_D)) && (cz_s14 >= -$signed(ONE_D)))
		else $error("z coordinate out of range");

	// The x and y coordinates lie within plus and minus one.
	a_cxy_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s14 |-> (cx_s14 <= $signed(ONE_D)) && (cx_s14 >= -$signed(ONE_D))
			&& (cy_s14 <= $signed(ONE_D)) && (cy_s14 >= -$signed(ONE_D)))
		else $error("x or y coordinate out of range");
`endif

endmodule

`default_nettype wire

/* test/sphere_surface_point_sampler_tb.sv */
// Self-checking testbench for the sphere surface point sampler: drives random pairs and
// APB register transactions, predicts every sphere point and checks each strobed result.
// Depends on ssps_pkg and the sphere_surface_point_sampler top level.

module sphere_surface_point_sampler_tb;
	import ssps_pkg::*;

	localparam int NUM_REGS = 6;
	localparam int UNIT_SCALE = 65536;
	localparam int RAND_TOP = (1 << RAND_BITS) - 1;
	localparam int SETTLE_CYCLES = LATENCY + 4;
	localparam int CYCLE_LIMIT = 100000;
	localparam int RANDOM_ITEMS = 550;
	localparam longint ONE_D_L = longint'(1) << FRAC_BITS;
	localparam longint ONE_S = longint'(1) << (2 * FRAC_BITS);
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;
	localparam logic [CFG_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [CFG_W-1:0] Q_MIN = 32'h8000_0000;

	// Pairs on and around the unit circle, the centre and the corners of the square.
	localparam logic [2*RAND_BITS-1:0] DIRECTED_PAIRS [20] = '{
		{16'd0, 16'd0}, {16'd0, 16'd32768}, {16'd32768, 16'd0}, {16'd32768, 16'd32768},
		{16'd65535, 16'd65535}, {16'd65535, 16'd32768}, {16'd32768, 16'd65535},
		{16'd32768, 16'd1}, {16'd1, 16'd32768}, {16'd16384, 16'd16384},
		{16'd49152, 16'd16384}, {16'd16384, 16'd49152}, {16'd49152, 16'd49152},
		{16'd32769, 16'd32767}, {16'd9598, 16'd9598}, {16'd9597, 16'd9597},
		{16'd55938, 16'd55938}, {16'd55939, 16'd55939}, {16'd65535, 16'd0},
		{16'd1, 16'd1}
	};
	localparam logic [RAND_BITS-1:0] CORNER_VALUES [7] = '{
		16'd0, 16'd1, 16'd32767, 16'd32768, 16'd32769, 16'd65534, 16'd65535
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [CFG_W-1:0] pwdata = '0;
	logic [CFG_W-1:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	sample_t sample = '0;
	logic point_valid;
	point_t point;

	longint reg_shadow [NUM_REGS];
	point_t pending_points [$];
	int errors = 0;
	int idle_pct = 0;
	int cycle_count = 0;

	sphere_surface_point_sampler dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.sample(sample),
		.point_valid(point_valid),
		.point(point)
	);

	always #5 clk = ~clk;

	// Guard against a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sphere_surface_point_sampler_tb failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Maps a random fraction to d = 1 - 2u at scale 2^-30.
	function automatic longint frac_to_d(input logic [RAND_BITS-1:0] r);
		longint q;
		q = r;
		return ONE_D_L - (q << (FRAC_BITS - RAND_BITS + 1));
	endfunction

	// Division by 2^k, rounding to nearest with ties towards plus infinity.
	function automatic longint round_shift(input longint v, input int k);
		return (v + (longint'(1) << (k - 1))) >>> k;
	endfunction

	// Floor of the square root, one root bit at a time; v never exceeds 2^60.
	function automatic longint floor_root(input longint v);
		longint r;
		longint t;
		r = 0;
		for (int i = FRAC_BITS; i >= 0; i--) begin
			t = r | (longint'(1) << i);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// Scales a Q2.30 coordinate, adds the origin and clamps to Q16.16.
	function automatic logic [CFG_W-1:0] place_on_axis(input longint c, input longint scale,
			input longint origin);
		longint v;
		v = round_shift(c * scale, FRAC_BITS) + origin;
		if (v > SAT_HI)
			return Q_MAX;
		if (v < SAT_LO)
			return Q_MIN;
		return v[CFG_W-1:0];
	endfunction

	// Returns whether the pair lands inside the disc, and the point it gives.
	function automatic bit predict_point(input sample_t pair, output point_t p);
		longint d1, d2, s_sum, root, cx, cy, cz;
		p = '0;
		d1 = frac_to_d(pair.rand_a);
		d2 = frac_to_d(pair.rand_b);
		s_sum = d1 * d1 + d2 * d2;
		if (s_sum >= ONE_S)
			return 1'b0;
		root = floor_root(ONE_S - s_sum);
		cx = round_shift(d1 * root, FRAC_BITS - 1);
		cy = round_shift(d2 * root, FRAC_BITS - 1);
		cz = round_shift(ONE_S - 2 * s_sum, FRAC_BITS);
		p.point_x = place_on_axis(cx, reg_shadow[REG_SCALE_X], reg_shadow[REG_ORIGIN_X]);
		p.point_y = place_on_axis(cy, reg_shadow[REG_SCALE_Y], reg_shadow[REG_ORIGIN_Y]);
		p.point_z = place_on_axis(cz, reg_shadow[REG_SCALE_Z], reg_shadow[REG_ORIGIN_Z]);
		return 1'b1;
	endfunction

	// Mostly uniform pairs, some hugging the circle and some at the corners.
	function automatic sample_t draw_sample();
		sample_t pair;
		longint d1, rim;
		int b;
		int pick;
		pick = $urandom_range(99);
		pair.rand_a = RAND_BITS'($urandom_range(RAND_TOP));
		pair.rand_b = RAND_BITS'($urandom_range(RAND_TOP));
		if (pick < 15) begin
			d1 = frac_to_d(pair.rand_a);
			rim = floor_root(ONE_S - d1 * d1);
			b = int'((ONE_D_L - rim) >>> (FRAC_BITS - RAND_BITS + 1));
			b = b + int'($urandom_range(6)) - 3;
			if (b < 0)
				b = 0;
			if (b > RAND_TOP)
				b = RAND_TOP;
			if ($urandom_range(1))
				b = (RAND_TOP + 1 - b) & RAND_TOP;
			pair.rand_b = RAND_BITS'(b);
			if ($urandom_range(1))
				pair = {pair.rand_b, pair.rand_a};
		end else if (pick < 25) begin
			pair.rand_a = CORNER_VALUES[$urandom_range(6)];
			pair.rand_b = CORNER_VALUES[$urandom_range(6)];
		end
		return pair;
	endfunction

	function automatic logic [CFG_W-1:0] random_q16(input int shift);
		return $signed($urandom) >>> shift;
	endfunction

	// Sends one pair, idling first at the current rate, and records the expected point, if any.
	task automatic send_sample(input sample_t pair);
		point_t want;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		sample <= pair;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		if (predict_point(pair, want))
			pending_points.push_back(want);
	endtask

	// Stops sending, waits for every outstanding point, then lets extra cycles pass.
	task automatic quiesce(input int extra);
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_points.size() != 0);
		repeat (extra)
			@(posedge clk);
	endtask

	task automatic cfg_write(input int index, input logic [CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(index * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		if (index < NUM_REGS)
			reg_shadow[index] = longint'($signed(value));
	endtask

	task automatic cfg_read(input int index, output logic [CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_W'(index * 4);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		value = prdata;
	endtask

	task automatic apb_release();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_readback();
		logic [CFG_W-1:0] got;
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_read(i, got);
			if (got !== reg_shadow[i][CFG_W-1:0])
				report_mismatch($sformatf("register %0d read %h expected %h", i, got,
					reg_shadow[i][CFG_W-1:0]));
		end
	endtask

	// Waits until the block is idle, then writes all six registers.
	task automatic apply_settings(input logic [CFG_W-1:0] ox, input logic [CFG_W-1:0] oy,
			input logic [CFG_W-1:0] oz, input logic [CFG_W-1:0] sx,
			input logic [CFG_W-1:0] sy, input logic [CFG_W-1:0] sz);
		quiesce(SETTLE_CYCLES);
		cfg_write(REG_ORIGIN_X, ox);
		cfg_write(REG_ORIGIN_Y, oy);
		cfg_write(REG_ORIGIN_Z, oz);
		cfg_write(REG_SCALE_X, sx);
		cfg_write(REG_SCALE_Y, sy);
		cfg_write(REG_SCALE_Z, sz);
		apb_release();
	endtask

	// Reset values, full-width read-back, writes beyond the last register, then eight pairs.
	task automatic test_register_access();
		check_readback();
		for (int i = 0; i < NUM_REGS; i++)
			cfg_write(i, random_q16(0));
		check_readback();
		cfg_write(NUM_REGS, random_q16(0));
		cfg_write(NUM_REGS + 1, random_q16(0));
		check_readback();
		apb_release();
		for (int i = 0; i < 8; i++)
			send_sample(draw_sample());
	endtask

	// Centre, corners, rejected pairs and pairs on either side of the unit circle.
	task automatic test_directed();
		apply_settings('0, '0, '0, UNIT_SCALE, UNIT_SCALE, UNIT_SCALE);
		foreach (DIRECTED_PAIRS[i])
			send_sample(sample_t'(DIRECTED_PAIRS[i]));
	endtask

	// Largest scales and origins of either sign, and zero scale, to drive saturation.
	task automatic test_saturation();
		apply_settings(Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN);
		for (int i = 0; i < 10; i++)
			send_sample(draw_sample());
		apply_settings(Q_MIN, Q_MAX, Q_MIN, '0, Q_MAX, Q_MAX);
		for (int i = 0; i < 10; i++)
			send_sample(draw_sample());
	endtask

	// Random traffic under random settings; halfway through the sender holds off
	// until every outstanding point has arrived.
	task automatic test_random(input int pct, input int origin_shift, input int scale_shift);
		apply_settings(random_q16(origin_shift), random_q16(origin_shift),
			random_q16(origin_shift), random_q16(scale_shift), random_q16(scale_shift),
			random_q16(scale_shift));
		idle_pct = pct;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				quiesce(0);
			send_sample(draw_sample());
		end
	endtask

	// Each strobed point is checked against the oldest expectation.
	always @(posedge clk) begin : point_checker
		point_t want;
		if (arst_n && point_valid !== 1'b0) begin
			if (pending_points.size() == 0) begin
				report_mismatch($sformatf("unexpected point %h", point));
			end else begin
				want = pending_points.pop_front();
				if (point.point_x !== want.point_x)
					report_mismatch($sformatf("point_x %h expected %h", point.point_x,
						want.point_x));
				if (point.point_y !== want.point_y)
					report_mismatch($sformatf("point_y %h expected %h", point.point_y,
						want.point_y));
				if (point.point_z !== want.point_z)
					report_mismatch($sformatf("point_z %h expected %h", point.point_z,
						want.point_z));
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_REGS; i++)
			reg_shadow[i] = (i >= REG_SCALE_X) ? UNIT_SCALE : 0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_directed();
		test_saturation();
		test_random(23, 8, 12);
		test_random(86, 0, 0);
		test_random(0, 8, 12);
		quiesce(SETTLE_CYCLES);
		if (errors == 0)
			$display("sphere_surface_point_sampler_tb passed");
		else
			$display("sphere_surface_point_sampler_tb failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/ssps_pkg.sv
rtl/core/ssps_sqrt.sv
rtl/core/sphere_surface_point_sampler.sv
test/sphere_surface_point_sampler_tb.sv
